// ----- rtl/dsse_pkg.sv -----
// ============================================================================
// dsse_pkg : shared types and constants of the decimal seven-segment encoder
// Holds the beat structures, the sequencer states, the conversion-core control
// group and the seven-segment decode table.
// ============================================================================
package dsse_pkg;

    // A 31-bit magnitude has at most ten decimal digits.
    localparam int unsigned MAG_BITS   = 31;
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned BCD_BITS   = 4 * NUM_DIGITS;

    typedef struct packed {
        logic signed [31:0] number_value;
        logic [11:0]        origin_x;
        logic [11:0]        origin_y;
    } in_beat_t;

    typedef struct packed {
        logic [6:0]  segment_mask;
        logic [3:0]  digit_value;
        logic [3:0]  slot_index;
        logic [12:0] pos_x;
        logic [11:0] pos_y;
        logic        last_digit;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_STRIP,
        ST_LIMIT,
        ST_EMIT
    } state_t;

    // Control group from the sequencer to the conversion core.
    typedef struct packed {
        logic load;         // take a fresh magnitude, clear the digits
        logic dabble;       // one add-3-and-shift step
        logic digit_shift;  // drop the top digit, move the rest up
    } core_ctrl_t;

    // Segment order: bit 0 top, clockwise, bit 6 middle.
    function automatic logic [6:0] seg_decode(input logic [3:0] digit);
        logic [6:0] mask;
        unique case (digit)
            4'd0:    mask = 7'h3F;
            4'd1:    mask = 7'h06;
            4'd2:    mask = 7'h5B;
            4'd3:    mask = 7'h4F;
            4'd4:    mask = 7'h66;
            4'd5:    mask = 7'h6D;
            4'd6:    mask = 7'h7D;
            4'd7:    mask = 7'h07;
            4'd8:    mask = 7'h7F;
            4'd9:    mask = 7'h6F;
            default: mask = 7'h00;
        endcase
        return mask;
    endfunction

endpackage

// ----- rtl/dsse_bcd_core.sv -----
// ============================================================================
// dsse_bcd_core : bit-serial binary to BCD converter and digit store
// Shift-and-add-3 over one magnitude bit per step; the finished digits are
// then moved up one digit per step so the top digit can be read out.
// ============================================================================
module dsse_bcd_core (
    input  logic                                clk,
    input  dsse_pkg::core_ctrl_t                ctrl,
    input  logic [dsse_pkg::MAG_BITS-1:0]       mag,
    output logic [3:0]                          top_digit
);

    logic [dsse_pkg::BCD_BITS-1:0] bcd_reg, bcd_next;
    logic [dsse_pkg::MAG_BITS-1:0] bin_reg, bin_next;
    logic [dsse_pkg::BCD_BITS-1:0] bcd_adj;

    // Add 3 to every digit of five or more before the doubling shift.
    always_comb
    begin
        for (int i = 0; i < dsse_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bcd_next = bcd_reg;
        bin_next = bin_reg;
        if (ctrl.load)
        begin
            bcd_next = '0;
            bin_next = mag;
        end
        else if (ctrl.dabble)
        begin
            bcd_next = {bcd_adj[dsse_pkg::BCD_BITS-2:0], bin_reg[dsse_pkg::MAG_BITS-1]};
            bin_next = {bin_reg[dsse_pkg::MAG_BITS-2:0], 1'b0};
        end
        else if (ctrl.digit_shift)
        begin
            bcd_next = {bcd_reg[dsse_pkg::BCD_BITS-5:0], 4'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign top_digit = bcd_reg[dsse_pkg::BCD_BITS-1 -: 4];

endmodule

// ----- rtl/decimal_seven_segment_encoder_unit.sv -----
// ============================================================================
// decimal_seven_segment_encoder_unit : value to seven-segment digit beats
// Clamps a signed value to zero or above, converts it to decimal, keeps at
// most DIGIT_LIMIT low digits without leading zeros, and sends one beat per
// digit, most significant first, with its mask, slot and pixel position.
//
// Channel    Signals                        Direction  Handshake
// ---------  -----------------------------  ---------  ---------------------------
// command    start, busy, item              in         taken when start && !busy
// result     result_valid, result           out        one cycle, cannot be held
// config     cfg_we, cfg_wdata (pitch)      in         written when cfg_we is high
//
// busy rises at the accepting edge and stays high while an item goes through
// the bit-serial conversion in the shared add-3-and-shift unit, the stripping
// of leading zeros, the dropping of digits above DIGIT_LIMIT and one result
// beat per digit. Stripped, dropped and sent digits always add up to ten; the
// next item is taken only after busy has fallen.
// Reset clears the sequencer and loads the pitch with 22; the digit store
// needs no clearing because every digit read was written by the same item.
// Result beats cannot be held; nothing downstream can stall them.
// ============================================================================
module decimal_seven_segment_encoder_unit #(
    parameter int unsigned DIGIT_LIMIT = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dsse_pkg::in_beat_t  item,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    output logic                result_valid,
    output dsse_pkg::out_beat_t result
);

    // The limit compared against the 4-bit digit count.
    localparam logic [3:0] LIMIT_C = 4'(DIGIT_LIMIT);
    localparam logic [4:0] LAST_BIT = 5'(dsse_pkg::MAG_BITS - 1);
    localparam logic [3:0] FULL_CNT = 4'(dsse_pkg::NUM_DIGITS);

    dsse_pkg::state_t     state_reg, state_next;
    dsse_pkg::core_ctrl_t ctrl;

    logic [4:0]  bit_cnt_reg, bit_cnt_next;
    // Digits still held from the top of the store down; this is the digit
    // count while trimming and the digits left to send while emitting.
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  slot_reg, slot_next;
    logic [12:0] x_reg, x_next;
    logic [11:0] y_reg, y_next;
    logic [7:0]  pitch_reg;

    logic [3:0]                          top_digit;
    logic [dsse_pkg::MAG_BITS-1:0]       mag;
    logic                                accept;

    assign accept = start && !busy;

    // A set sign bit clamps the value to zero.
    assign mag = item.number_value[31] ? '0 : item.number_value[dsse_pkg::MAG_BITS-1:0];

    dsse_bcd_core u_core (
        .clk       (clk),
        .ctrl      (ctrl),
        .mag       (mag),
        .top_digit (top_digit)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dsse_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = dsse_pkg::ST_CONVERT;
            end
            dsse_pkg::ST_CONVERT:
            begin
                if (bit_cnt_reg == LAST_BIT)
                    state_next = dsse_pkg::ST_STRIP;
            end
            dsse_pkg::ST_STRIP:
            begin
                // Leading zeros go first; a lone zero digit stays.
                if (!(top_digit == 4'd0 && cnt_reg > 4'd1))
                    state_next = dsse_pkg::ST_LIMIT;
            end
            dsse_pkg::ST_LIMIT:
            begin
                if (cnt_reg <= LIMIT_C)
                    state_next = dsse_pkg::ST_EMIT;
            end
            dsse_pkg::ST_EMIT:
            begin
                if (cnt_reg == 4'd1)
                    state_next = dsse_pkg::ST_IDLE;
            end
            default: state_next = dsse_pkg::ST_IDLE;
        endcase
    end

    // Outputs, core control and datapath register updates.
    always_comb
    begin
        ctrl         = '0;
        bit_cnt_next = bit_cnt_reg;
        cnt_next     = cnt_reg;
        slot_next    = slot_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        result_valid = 1'b0;
        unique case (state_reg)
            dsse_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load    = 1'b1;
                    bit_cnt_next = '0;
                    cnt_next     = FULL_CNT;
                    slot_next    = '0;
                    x_next       = {1'b0, item.origin_x};
                    y_next       = item.origin_y;
                end
            end
            dsse_pkg::ST_CONVERT:
            begin
                ctrl.dabble  = 1'b1;
                bit_cnt_next = bit_cnt_reg + 5'd1;
            end
            dsse_pkg::ST_STRIP:
            begin
                if (top_digit == 4'd0 && cnt_reg > 4'd1)
                begin
                    ctrl.digit_shift = 1'b1;
                    cnt_next         = cnt_reg - 4'd1;
                end
            end
            dsse_pkg::ST_LIMIT:
            begin
                // Digits above the limit are dropped, zeros below them stay.
                if (cnt_reg > LIMIT_C)
                begin
                    ctrl.digit_shift = 1'b1;
                    cnt_next         = cnt_reg - 4'd1;
                end
            end
            dsse_pkg::ST_EMIT:
            begin
                result_valid = 1'b1;
                if (cnt_reg != 4'd1)
                begin
                    ctrl.digit_shift = 1'b1;
                    cnt_next         = cnt_reg - 4'd1;
                    slot_next        = slot_reg + 4'd1;
                    x_next           = x_reg + {5'd0, pitch_reg};
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign busy = (state_reg != dsse_pkg::ST_IDLE);

    always_comb
    begin
        result.segment_mask = dsse_pkg::seg_decode(top_digit);
        result.digit_value  = top_digit;
        result.slot_index   = slot_reg;
        result.pos_x        = x_reg;
        result.pos_y        = y_reg;
        result.last_digit   = (cnt_reg == 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dsse_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            cnt_reg     <= '0;
            pitch_reg   <= 8'd22;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            cnt_reg     <= cnt_next;
            if (cfg_we)
                pitch_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
    end

endmodule
